[hdl/itoa_pkg.sv]
// Shared types, constants and character helpers for the integer-to-ASCII formatter.
package itoa_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIG_DEPTH   = 11;
  localparam int unsigned DIG_IDX_W   = $clog2(DIG_DEPTH);

  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    MODE_CHAR = 3'd0,
    MODE_UDEC = 3'd1,
    MODE_SDEC = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_OCT  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] mag;
    logic        neg;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_UPPER + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

[hdl/itoa_front.sv]
// Front end: accepts input beats, decodes the format and forms the magnitude.
module itoa_front (
  input  logic                 in_valid,
  input  itoa_pkg::in_item_t   in_data,
  output logic                 in_stall,
  input  logic                 q_full,
  output logic                 push,
  output itoa_pkg::job_t       job
);

  logic func_ok;
  logic neg;

  always_comb begin
    func_ok = 1'b1;
    case (in_data.func)
      itoa_pkg::MODE_CHAR: job.mode = itoa_pkg::MODE_CHAR;
      itoa_pkg::MODE_UDEC: job.mode = itoa_pkg::MODE_UDEC;
      itoa_pkg::MODE_SDEC: job.mode = itoa_pkg::MODE_SDEC;
      itoa_pkg::MODE_HEX:  job.mode = itoa_pkg::MODE_HEX;
      itoa_pkg::MODE_OCT:  job.mode = itoa_pkg::MODE_OCT;
      default: begin
        job.mode = itoa_pkg::MODE_CHAR;
        func_ok  = 1'b0;
      end
    endcase
    neg      = (job.mode == itoa_pkg::MODE_SDEC) && in_data.value[31];
    job.neg  = neg;
    job.mag  = neg ? (32'd0 - in_data.value) : in_data.value;
  end

  // Undefined selectors are accepted and dropped without taking a queue slot.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && func_ok;

endmodule

[hdl/itoa_queue.sv]
// Small register queue that decouples the front end from the converter.
module itoa_queue #(
  parameter int unsigned Depth = itoa_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  itoa_pkg::job_t wr_job,
  input  logic           pop,
  output itoa_pkg::job_t rd_job,
  output logic           full,
  output logic           empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  itoa_pkg::job_t  slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CntW'(Depth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

[hdl/itoa_back.sv]
// Back end: converts one job to digits and sends its characters as output beats.
module itoa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itoa_pkg::job_t       job,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  output itoa_pkg::out_item_t  out_data,
  input  logic                 out_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_LEAD,
    S_X,
    S_DIG,
    S_SPACE
  } state_t;

  localparam int unsigned DigW = itoa_pkg::DIG_IDX_W;

  state_t                state_r, state_nxt;
  itoa_pkg::mode_t       mode_r, mode_nxt;
  logic [31:0]           mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [DigW-1:0]       ndig_r, ndig_nxt;
  logic [3:0]            dig_r [itoa_pkg::DIG_DEPTH];
  logic [3:0]            dig_nxt [itoa_pkg::DIG_DEPTH];
  logic                  out_valid_r, out_valid_nxt;
  itoa_pkg::out_item_t   out_data_r, out_data_nxt;

  logic                  out_free;
  logic [63:0]           prod;
  logic [31:0]           quot;
  logic [3:0]            q_times_ten;
  logic [3:0]            conv_digit;
  logic [31:0]           conv_next;
  logic [DigW-1:0]       top_idx;

  // Decimal digits use a multiply by the scaled reciprocal of ten.
  always_comb begin
    prod        = {32'd0, mag_r} * {32'd0, itoa_pkg::RECIP_TEN};
    quot        = {3'd0, prod[63:itoa_pkg::RECIP_SHIFT]};
    q_times_ten = {quot[0], 3'b000} + {quot[2:0], 1'b0};
    case (mode_r)
      itoa_pkg::MODE_HEX: begin
        conv_digit = mag_r[3:0];
        conv_next  = {4'd0, mag_r[31:4]};
      end
      itoa_pkg::MODE_OCT: begin
        conv_digit = {1'b0, mag_r[2:0]};
        conv_next  = {3'd0, mag_r[31:3]};
      end
      default: begin
        conv_digit = mag_r[3:0] - q_times_ten;
        conv_next  = quot;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign top_idx  = ndig_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    ndig_nxt      = ndig_r;
    dig_nxt       = dig_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          mode_nxt = job.mode;
          mag_nxt  = job.mag;
          neg_nxt  = job.neg;
          ndig_nxt = '0;
          if (job.mode == itoa_pkg::MODE_CHAR ||
              (job.mode == itoa_pkg::MODE_OCT && job.mag == 32'd0)) begin
            state_nxt = S_LEAD;
          end else begin
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        dig_nxt[ndig_r] = conv_digit;
        ndig_nxt        = ndig_r + 1'b1;
        mag_nxt         = conv_next;
        if (conv_next == 32'd0) begin
          if (mode_r == itoa_pkg::MODE_HEX || mode_r == itoa_pkg::MODE_OCT ||
              (mode_r == itoa_pkg::MODE_SDEC && neg_r)) begin
            state_nxt = S_LEAD;
          end else begin
            state_nxt = S_DIG;
          end
        end
      end
      S_LEAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (mode_r == itoa_pkg::MODE_CHAR) begin
            out_data_nxt.ascii_char = mag_r[7:0];
          end else if (mode_r == itoa_pkg::MODE_SDEC) begin
            out_data_nxt.ascii_char = itoa_pkg::CH_MINUS;
          end else begin
            out_data_nxt.ascii_char = itoa_pkg::CH_ZERO;
          end
          out_data_nxt.last_char = (mode_r == itoa_pkg::MODE_CHAR) ||
                                   (mode_r == itoa_pkg::MODE_OCT && ndig_r == '0);
          if (out_data_nxt.last_char) begin
            state_nxt = S_IDLE;
          end else if (mode_r == itoa_pkg::MODE_HEX) begin
            state_nxt = S_X;
          end else begin
            state_nxt = S_DIG;
          end
        end
      end
      S_X: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.ascii_char = itoa_pkg::CH_X;
          out_data_nxt.last_char  = 1'b0;
          state_nxt               = S_DIG;
        end
      end
      S_DIG: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.ascii_char = itoa_pkg::digit_char(dig_r[top_idx]);
          out_data_nxt.last_char  = (ndig_r == DigW'(1)) &&
                                    (mode_r != itoa_pkg::MODE_UDEC);
          ndig_nxt                = top_idx;
          if (ndig_r == DigW'(1)) begin
            state_nxt = (mode_r == itoa_pkg::MODE_UDEC) ? S_SPACE : S_IDLE;
          end
        end
      end
      S_SPACE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.ascii_char = itoa_pkg::CH_SPACE;
          out_data_nxt.last_char  = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    ndig_r     <= ndig_nxt;
    dig_r      <= dig_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/integer_to_ascii_formatter_core.sv]
// Top level of the integer-to-ASCII formatter: front end, job queue and converter.
// Each input beat carries a format selector and a 32-bit value; the block answers with
// one output beat per ASCII character, most significant first, with last_char set on
// the final one, and drops selectors 5 to 7 without output. The front end decodes and
// queues jobs while the single back-end converter works on one job at a time: it picks up
// a job, forms its digits one per step (decimal through a reciprocal multiply, hex and
// octal by shifting; char mode and octal zero skip this), then sends one character per
// step, holding while the output channel stalls. The longest output is octal of an
// all-ones value: 11 digits and 12 characters. Because all digits are formed before the
// first character leaves, digit forming adds to the time spent on characters.
module integer_to_ascii_formatter_core #(
  parameter int unsigned QueueDepth = itoa_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  itoa_pkg::in_item_t   in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output itoa_pkg::out_item_t  out_data,
  input  logic                 out_stall
);

  itoa_pkg::job_t wr_job;
  itoa_pkg::job_t rd_job;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  itoa_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .job      (wr_job)
  );

  itoa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (rd_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the integer-to-ASCII formatter: random beats, stalls and checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned SETTLE_TICKS = 64;
  localparam int unsigned RANDOM_ITEMS = 170;
  localparam int unsigned QUIET_ITEMS  = 30;
  localparam int unsigned PRINT_CAP    = 100;
  localparam logic [2:0]  FUNC_UNDEF_LO  = 3'd5;
  localparam logic [2:0]  FUNC_UNDEF_MID = 3'd6;
  localparam logic [2:0]  FUNC_UNDEF_HI  = 3'd7;
  localparam logic [8*16-1:0] GLYPHS = "0123456789ABCDEF";

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  itoa_pkg::in_item_t  in_data = '0;
  logic                in_stall;
  logic                out_valid;
  itoa_pkg::out_item_t out_data;
  logic                out_stall = 1'b0;

  itoa_pkg::in_item_t  send_items[$];
  itoa_pkg::out_item_t awaited_chars[$];
  itoa_pkg::out_item_t want;
  int unsigned n_errors = 0;
  int unsigned stuck_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;
  bit          quiet = 1'b0;
  bit          nxt_valid;
  bit          nxt_stall;

  integer_to_ascii_formatter_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string what);
    if (n_errors < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
    n_errors++;
  endtask

  function automatic void format_text(input itoa_pkg::in_item_t item);
    logic [7:0]  text [12];
    logic [7:0]  rev [32];
    logic [31:0] mag;
    logic [31:0] radix;
    logic [31:0] d;
    int          len;
    int          n;
    int          i;
    bit          digits;
    len = 0;
    n = 0;
    digits = 1'b0;
    mag = item.value;
    radix = 32'd10;
    case (item.func)
      itoa_pkg::MODE_CHAR: begin
        text[0] = item.value[7:0];
        len = 1;
      end
      itoa_pkg::MODE_UDEC: begin
        digits = 1'b1;
      end
      itoa_pkg::MODE_SDEC: begin
        if (item.value[31]) begin
          text[0] = "-";
          len = 1;
          mag = 32'd0 - item.value;
        end
        digits = 1'b1;
      end
      itoa_pkg::MODE_HEX: begin
        text[0] = "0";
        text[1] = "x";
        len = 2;
        radix = 32'd16;
        digits = 1'b1;
      end
      itoa_pkg::MODE_OCT: begin
        text[0] = "0";
        len = 1;
        radix = 32'd8;
        digits = (item.value != 32'd0);
      end
      default: begin
        return;
      end
    endcase
    if (digits) begin
      do begin
        d = mag % radix;
        rev[n] = GLYPHS[8*(15-d) +: 8];
        n++;
        mag = mag / radix;
      end while (mag != 32'd0);
      for (i = n - 1; i >= 0; i--) begin
        text[len] = rev[i];
        len++;
      end
    end
    if (item.func == itoa_pkg::MODE_UDEC) begin
      text[len] = " ";
      len++;
    end
    for (i = 0; i < len; i++) begin
      awaited_chars.push_back('{ascii_char: text[i], last_char: logic'(i == len - 1)});
    end
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    int          k;
    p = 32'd1;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 20);
      3: return 32'h8000_0000 + $urandom_range(0, 3) - 32'd2;
      4: begin
        k = $urandom_range(0, 9);
        repeat (k) p = p * 32'd10;
        return p + $urandom_range(0, 2) - 32'd1;
      end
      default: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
    endcase
  endfunction

  task automatic queue_item(input logic [2:0] func, input logic [31:0] value);
    send_items.push_back('{func: func, value: value});
  endtask

  task automatic drain();
    while (send_items.size() != 0 || in_valid || awaited_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        format_text(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (send_items.size() != 0) begin
          if (!quiet && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(0, 5);
          end else begin
            in_data <= send_items.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat char 0x%02h last %0b",
                                  out_data.ascii_char, out_data.last_char));
        end else begin
          want = awaited_chars.pop_front();
          if (out_data.ascii_char !== want.ascii_char) begin
            flag_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h",
                                    out_data.ascii_char, want.ascii_char));
          end
          if (out_data.last_char !== want.last_char) begin
            flag_mismatch($sformatf("last_char %0b, expected %0b",
                                    out_data.last_char, want.last_char));
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        nxt_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        recv_hold = $urandom_range(0, 5);
        nxt_stall = 1'b1;
      end else begin
        nxt_stall = 1'b0;
      end
      out_stall <= nxt_stall;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned counted;
    logic [2:0]  func;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    queue_item(itoa_pkg::MODE_CHAR, 32'h0000_0000);
    queue_item(itoa_pkg::MODE_CHAR, 32'hFFFF_FFFF);
    queue_item(itoa_pkg::MODE_CHAR, 32'h1234_5641);
    queue_item(itoa_pkg::MODE_UDEC, 32'd0);
    queue_item(itoa_pkg::MODE_UDEC, 32'd9);
    queue_item(itoa_pkg::MODE_UDEC, 32'd10);
    queue_item(itoa_pkg::MODE_UDEC, 32'hFFFF_FFFF);
    queue_item(itoa_pkg::MODE_SDEC, 32'd0);
    queue_item(itoa_pkg::MODE_SDEC, 32'd5);
    queue_item(itoa_pkg::MODE_SDEC, 32'h7FFF_FFFF);
    queue_item(itoa_pkg::MODE_SDEC, 32'h8000_0000);
    queue_item(itoa_pkg::MODE_SDEC, 32'hFFFF_FFFF);
    queue_item(itoa_pkg::MODE_HEX,  32'd0);
    queue_item(itoa_pkg::MODE_HEX,  32'd10);
    queue_item(itoa_pkg::MODE_HEX,  32'hFFFF_FFFF);
    queue_item(itoa_pkg::MODE_HEX,  32'h8000_0000);
    queue_item(itoa_pkg::MODE_OCT,  32'd0);
    queue_item(itoa_pkg::MODE_OCT,  32'd7);
    queue_item(itoa_pkg::MODE_OCT,  32'd8);
    queue_item(itoa_pkg::MODE_OCT,  32'hFFFF_FFFF);
    queue_item(FUNC_UNDEF_LO, 32'hFFFF_FFFF);
    queue_item(FUNC_UNDEF_MID, 32'h0000_0000);
    queue_item(FUNC_UNDEF_HI, 32'h5A5A_A5A5);
    queue_item(itoa_pkg::MODE_UDEC, 32'd1);
    drain();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) begin
        func = 3'($urandom_range(FUNC_UNDEF_LO, FUNC_UNDEF_HI));
      end else begin
        func = 3'($urandom_range(itoa_pkg::MODE_CHAR, itoa_pkg::MODE_OCT));
        counted++;
      end
      queue_item(func, pick_value());
      if (counted == RANDOM_ITEMS - QUIET_ITEMS) begin
        drain();
        quiet = 1'b1;
      end
    end
    drain();
    repeat (SETTLE_TICKS) @(posedge clk);

    if (awaited_chars.size() != 0) begin
      flag_mismatch($sformatf("%0d characters never arrived", awaited_chars.size()));
    end
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/itoa_pkg.sv
hdl/itoa_front.sv
hdl/itoa_queue.sv
hdl/itoa_back.sv
hdl/integer_to_ascii_formatter_core.sv
tb/tb_top.sv
